// File: rtl/core/sos_pkg.sv
package sos_pkg;

   localparam int MAX_OBJECTS_DEF = 32;
   localparam int Q               = 28;
   localparam int ANGLE_W         = 8;
   localparam int DIST_W          = 9;
   localparam int NUM_W           = 6;
   localparam int MID_W           = 9;
   localparam int LIN_W           = 12;
   localparam int SIN_W           = 30;
   localparam int DIST8_W         = DIST_W + 3;
   localparam int PROD_W          = DIST8_W + SIN_W;
   localparam int SIN_DEPTH       = 1 << ANGLE_W;

   localparam logic [DIST_W-1:0] THRESHOLD_RESET = DIST_W'(100);
   localparam logic [LIN_W-1:0]  LIN_MAX         = {LIN_W{1'b1}};

   typedef enum logic {
      ACTION_SAMPLE = 1'b0,
      ACTION_END    = 1'b1
   } action_type;

   typedef enum logic {
      KIND_OBJECT  = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [NUM_W-1:0]      number;
      logic [MID_W-1:0]      mid;
      logic [DIST_W-1:0]     distance;
      logic [ANGLE_W-1:0]    radial;
   } obj_type;

   typedef struct packed {
      obj_type               obj;
      logic [PROD_W-1:0]     prod;
   } chord_type;

   typedef logic [SIN_W-1:0] sin_table_type [SIN_DEPTH];

   typedef longint unsigned sin_div_type [6];
   localparam sin_div_type SIN_DIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

   function automatic sin_table_type build_sin_table();
      sin_table_type   tbl;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      for (int r = 0; r < SIN_DEPTH; r++) begin
         x    = (((longint'(r) * 64'd31415) << Q) + 64'd1800000) / 64'd3600000;
         x2   = (x * x) >> Q;
         term = x;
         sum  = longint'(x);
         for (int k = 1; k <= 6; k++) begin
            term = ((term * x2) >> Q) / SIN_DIV[k-1];
            if ((k % 2) == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         tbl[r] = SIN_W'(sum);
      end
      return tbl;
   endfunction

   localparam sin_table_type SIN_TABLE = build_sin_table();

endpackage

// File: rtl/core/sos_channels.sv
interface sos_req_if;
   logic                           valid;
   logic                           ready;
   logic                           action;
   logic [sos_pkg::ANGLE_W-1:0]    angle_deg;
   logic [sos_pkg::DIST_W-1:0]     distance_cm;

   modport source (output valid, output action, output angle_deg, output distance_cm,
                   input ready);
   modport sink   (input valid, input action, input angle_deg, input distance_cm,
                   output ready);
endinterface

interface sos_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           kind;
   logic [sos_pkg::NUM_W-1:0]      object_number;
   logic [sos_pkg::MID_W-1:0]      mid_angle_half_deg;
   logic [sos_pkg::DIST_W-1:0]     object_distance;
   logic [sos_pkg::ANGLE_W-1:0]    radial_width_deg;
   logic [sos_pkg::LIN_W-1:0]      linear_width_q2;

   modport source (output valid, output kind, output object_number, output mid_angle_half_deg,
                   output object_distance, output radial_width_deg, output linear_width_q2,
                   input ready);
   modport sink   (input valid, input kind, input object_number, input mid_angle_half_deg,
                   input object_distance, input radial_width_deg, input linear_width_q2,
                   output ready);
endinterface

interface sos_csr_if;
   logic                           valid;
   logic                           ready;
   logic [sos_pkg::DIST_W-1:0]     data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/sos_run_tracker.sv
module sos_run_tracker #(
   parameter int MAX_OBJECTS = sos_pkg::MAX_OBJECTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   sos_req_if.sink                       req_ch,
   input  logic [sos_pkg::DIST_W-1:0]    threshold,
   output logic                          obj_valid,
   input  logic                          obj_ready,
   output sos_pkg::obj_type              obj
);

   logic                           a_valid_ff, a_valid_in;
   logic                           a_action_ff;
   logic [sos_pkg::ANGLE_W-1:0]    a_angle_ff;
   logic [sos_pkg::DIST_W-1:0]     a_dist_ff;

   logic                           in_run_ff, in_run_in;
   logic [sos_pkg::ANGLE_W-1:0]    start_ff, start_in;
   logic [sos_pkg::ANGLE_W-1:0]    end_ff, end_in;
   logic [sos_pkg::DIST_W-1:0]     run_dist_ff, run_dist_in;
   logic [sos_pkg::NUM_W-1:0]      count_ff, count_in;

   logic                           produce;
   logic                           drain;
   logic                           accept;
   sos_pkg::obj_type               obj_next;

   assign drain        = a_valid_ff && (!produce || obj_ready);
   assign req_ch.ready = !a_valid_ff || drain;
   assign accept       = req_ch.valid && req_ch.ready;
   assign a_valid_in   = accept ? 1'b1 : (drain ? 1'b0 : a_valid_ff);
   assign obj_valid    = a_valid_ff && produce;
   assign obj          = obj_next;

   always_comb begin
      produce           = 1'b0;
      in_run_in         = in_run_ff;
      start_in          = start_ff;
      end_in            = end_ff;
      run_dist_in       = run_dist_ff;
      count_in          = count_ff;
      obj_next.kind     = sos_pkg::KIND_OBJECT;
      obj_next.number   = count_ff + sos_pkg::NUM_W'(1);
      obj_next.mid      = sos_pkg::MID_W'(start_ff) + sos_pkg::MID_W'(end_ff);
      obj_next.distance = run_dist_ff;
      obj_next.radial   = (end_ff > start_ff) ? (end_ff - start_ff) : (start_ff - end_ff);
      if (a_action_ff == sos_pkg::ACTION_END) begin
         produce       = 1'b1;
         obj_next.kind = sos_pkg::KIND_SUMMARY;
         in_run_in     = 1'b0;
         start_in      = '0;
         end_in        = '0;
         run_dist_in   = '0;
         count_in      = '0;
      end else if (a_dist_ff < threshold) begin
         if (!in_run_ff) begin
            start_in = a_angle_ff;
         end
         in_run_in   = 1'b1;
         run_dist_in = a_dist_ff;
         end_in      = a_angle_ff;
      end else if (in_run_ff && (end_ff != start_ff)) begin
         in_run_in   = 1'b0;
         start_in    = '0;
         end_in      = '0;
         run_dist_in = '0;
         if (count_ff < sos_pkg::NUM_W'(MAX_OBJECTS)) begin
            produce  = 1'b1;
            count_in = count_ff + sos_pkg::NUM_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         in_run_ff   <= 1'b0;
         start_ff    <= '0;
         end_ff      <= '0;
         run_dist_ff <= '0;
         count_ff    <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (drain) begin
            in_run_ff   <= in_run_in;
            start_ff    <= start_in;
            end_ff      <= end_in;
            run_dist_ff <= run_dist_in;
            count_ff    <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_action_ff <= req_ch.action;
         a_angle_ff  <= req_ch.angle_deg;
         a_dist_ff   <= req_ch.distance_cm;
      end
   end

endmodule

// File: rtl/core/sos_chord_unit.sv
module sos_chord_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 obj_valid,
   output logic                 obj_ready,
   input  sos_pkg::obj_type     obj,
   output logic                 chord_valid,
   input  logic                 chord_ready,
   output sos_pkg::chord_type   chord
);

   logic                           s1_valid_ff, s1_valid_in;
   sos_pkg::obj_type               s1_obj_ff;
   logic [sos_pkg::SIN_W-1:0]      s1_sin_ff;
   logic                           s1_ready;

   logic                           s2_valid_ff, s2_valid_in;
   sos_pkg::chord_type             s2_chord_ff, s2_chord_in;
   logic                           s2_ready;

   logic [sos_pkg::DIST8_W-1:0]    dist8;

   assign s2_ready    = !s2_valid_ff || chord_ready;
   assign s1_ready    = !s1_valid_ff || s2_ready;
   assign obj_ready   = s1_ready;
   assign s1_valid_in = s1_ready ? obj_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   assign chord_valid = s2_valid_ff;
   assign chord       = s2_chord_ff;

   always_comb begin
      dist8            = {s1_obj_ff.distance, 3'b000};
      s2_chord_in.obj  = s1_obj_ff;
      s2_chord_in.prod = sos_pkg::PROD_W'(dist8) * sos_pkg::PROD_W'(s1_sin_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (obj_valid && s1_ready) begin
         s1_obj_ff <= obj;
         s1_sin_ff <= sos_pkg::SIN_TABLE[obj.radial];
      end
      if (s1_valid_ff && s2_ready) begin
         s2_chord_ff <= s2_chord_in;
      end
   end

endmodule

// File: rtl/core/sos_best_tracker.sv
module sos_best_tracker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 chord_valid,
   output logic                 chord_ready,
   input  sos_pkg::chord_type   chord,
   sos_rsp_if.source            rsp_ch
);

   localparam int RND_W = sos_pkg::PROD_W - sos_pkg::Q;

   logic                           rsp_valid_ff, rsp_valid_in;
   sos_pkg::obj_type               rsp_obj_ff, rsp_obj_in;
   logic [sos_pkg::LIN_W-1:0]      rsp_lin_ff, rsp_lin_in;

   logic                           best_valid_ff, best_valid_in;
   sos_pkg::obj_type               best_obj_ff, best_obj_in;
   logic [sos_pkg::LIN_W-1:0]      best_lin_ff, best_lin_in;

   logic [sos_pkg::PROD_W-1:0]     rounded;
   logic [RND_W-1:0]               scaled;
   logic [sos_pkg::LIN_W-1:0]      lin;
   logic                           fire;

   assign chord_ready  = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = chord_valid && chord_ready;
   assign rsp_valid_in = fire ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      rounded = chord.prod + (sos_pkg::PROD_W'(1) << (sos_pkg::Q - 1));
      scaled  = rounded[sos_pkg::PROD_W-1:sos_pkg::Q];
      lin     = (scaled > RND_W'(sos_pkg::LIN_MAX)) ? sos_pkg::LIN_MAX
                                                    : scaled[sos_pkg::LIN_W-1:0];
   end

   always_comb begin
      best_valid_in = best_valid_ff;
      best_obj_in   = best_obj_ff;
      best_lin_in   = best_lin_ff;
      rsp_obj_in    = chord.obj;
      rsp_lin_in    = lin;
      if (chord.obj.kind == sos_pkg::KIND_SUMMARY) begin
         rsp_obj_in.kind = sos_pkg::KIND_SUMMARY;
         if (best_valid_ff) begin
            rsp_obj_in.number   = best_obj_ff.number;
            rsp_obj_in.mid      = best_obj_ff.mid;
            rsp_obj_in.distance = best_obj_ff.distance;
            rsp_obj_in.radial   = best_obj_ff.radial;
            rsp_lin_in          = best_lin_ff;
         end else begin
            rsp_obj_in.number   = '0;
            rsp_obj_in.mid      = '0;
            rsp_obj_in.distance = '0;
            rsp_obj_in.radial   = '0;
            rsp_lin_in          = '0;
         end
         best_valid_in = 1'b0;
      end else if (!best_valid_ff || (lin < best_lin_ff)) begin
         best_valid_in = 1'b1;
         best_obj_in   = chord.obj;
         best_lin_in   = lin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            best_valid_ff <= best_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_obj_ff  <= rsp_obj_in;
         rsp_lin_ff  <= rsp_lin_in;
         best_obj_ff <= best_obj_in;
         best_lin_ff <= best_lin_in;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.kind               = rsp_obj_ff.kind;
   assign rsp_ch.object_number      = rsp_obj_ff.number;
   assign rsp_ch.mid_angle_half_deg = rsp_obj_ff.mid;
   assign rsp_ch.object_distance    = rsp_obj_ff.distance;
   assign rsp_ch.radial_width_deg   = rsp_obj_ff.radial;
   assign rsp_ch.linear_width_q2    = rsp_lin_ff;

endmodule

// File: rtl/core/sweep_object_segmenter_unit.sv
// Sweep object segmenter.
// req_ch takes one request per cycle when not stalled: a range sample (angle,
// distance) or an end-of-sweep marker. A sample closer than the threshold
// opens or extends a run; the first far sample after a run of nonzero width
// closes it and, up to MAX_OBJECTS per sweep, yields one object response with
// midpoint, distance, angular width and chord width. An end-of-sweep request
// yields one summary response (narrowest object) and clears the sweep state.
// csr_ch writes the detection threshold; it is always ready and the value
// takes effect for requests processed after the write.
// Pipeline: a request passes the input register, chord table lookup, chord
// multiply and result register before its response is valid on rsp_ch.
// Throughput: one request per cycle while rsp_ch does not stall; samples that
// close nothing leave no trace downstream.
// Reset clears the pipeline, the run and sweep state, and restores the
// threshold to 100 cm. When rsp_ch stalls, the pipeline stages fill one by
// one and req_ch.ready drops only once the input register cannot drain.
module sweep_object_segmenter_unit #(
   parameter int MAX_OBJECTS = sos_pkg::MAX_OBJECTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sos_req_if.sink     req_ch,
   sos_rsp_if.source   rsp_ch,
   sos_csr_if.sink     csr_ch
);

   logic [sos_pkg::DIST_W-1:0]  threshold_ff;
   logic                        obj_valid;
   logic                        obj_ready;
   sos_pkg::obj_type            obj;
   logic                        chord_valid;
   logic                        chord_ready;
   sos_pkg::chord_type          chord;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= sos_pkg::THRESHOLD_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         threshold_ff <= csr_ch.data;
      end
   end

   sos_run_tracker #(
      .MAX_OBJECTS (MAX_OBJECTS)
   ) u_run (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .threshold (threshold_ff),
      .obj_valid (obj_valid),
      .obj_ready (obj_ready),
      .obj       (obj)
   );

   sos_chord_unit u_chord (
      .clock       (clock),
      .reset       (reset),
      .obj_valid   (obj_valid),
      .obj_ready   (obj_ready),
      .obj         (obj),
      .chord_valid (chord_valid),
      .chord_ready (chord_ready),
      .chord       (chord)
   );

   sos_best_tracker u_best (
      .clock       (clock),
      .reset       (reset),
      .chord_valid (chord_valid),
      .chord_ready (chord_ready),
      .chord       (chord),
      .rsp_ch      (rsp_ch)
   );

endmodule

// File: rtl/core/sos_checker.sv
module sos_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_kind,
   input logic [sos_pkg::NUM_W-1:0]     rsp_number,
   input logic [sos_pkg::MID_W-1:0]     rsp_mid,
   input logic [sos_pkg::DIST_W-1:0]    rsp_dist,
   input logic [sos_pkg::ANGLE_W-1:0]   rsp_radial,
   input logic [sos_pkg::LIN_W-1:0]     rsp_lin
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_number)
         && $stable(rsp_mid) && $stable(rsp_dist) && $stable(rsp_radial) && $stable(rsp_lin))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_object_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == sos_pkg::KIND_OBJECT) |-> (rsp_number != '0) && (rsp_radial != '0))
      else $error("object response with zero number or width");

   a_empty_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == sos_pkg::KIND_SUMMARY) && (rsp_number == '0)
         |-> (rsp_mid == '0) && (rsp_dist == '0) && (rsp_radial == '0) && (rsp_lin == '0))
      else $error("empty summary carries data");

   a_mid_covers_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mid >= sos_pkg::MID_W'(rsp_radial))
      else $error("midpoint sum below angular width");

endmodule

bind sweep_object_segmenter_unit sos_checker u_sos_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_kind   (rsp_ch.kind),
   .rsp_number (rsp_ch.object_number),
   .rsp_mid    (rsp_ch.mid_angle_half_deg),
   .rsp_dist   (rsp_ch.object_distance),
   .rsp_radial (rsp_ch.radial_width_deg),
   .rsp_lin    (rsp_ch.linear_width_q2)
);

// File: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      sos_pkg::kind_type                kind;
      logic [sos_pkg::NUM_W-1:0]        number;
      logic [sos_pkg::MID_W-1:0]        mid;
      logic [sos_pkg::DIST_W-1:0]       distance;
      logic [sos_pkg::ANGLE_W-1:0]      radial;
      logic [sos_pkg::LIN_W-1:0]        chord;
   } sweep_result_type;

   class sweep_scoreboard;
      logic [sos_pkg::DIST_W-1:0]    threshold;
      bit                            in_run;
      logic [sos_pkg::ANGLE_W-1:0]   run_first;
      logic [sos_pkg::ANGLE_W-1:0]   run_last;
      logic [sos_pkg::DIST_W-1:0]    run_dist;
      int                            found;
      bit                            have_best;
      sweep_result_type              best;
      sweep_result_type              awaited[$];
      int                            mismatches;
      int                            objects_checked;
      int                            summaries_checked;
      int                            capacity_drops;

      function new();
         threshold         = sos_pkg::THRESHOLD_RESET;
         mismatches        = 0;
         objects_checked   = 0;
         summaries_checked = 0;
         capacity_drops    = 0;
         restart_sweep();
      endfunction

      function void restart_sweep();
         in_run    = 1'b0;
         run_first = '0;
         run_last  = '0;
         run_dist  = '0;
         found     = 0;
         have_best = 1'b0;
         best      = '0;
      endfunction

      function logic [sos_pkg::LIN_W-1:0] chord_q2(logic [sos_pkg::DIST_W-1:0] d,
                                                   logic [sos_pkg::ANGLE_W-1:0] r);
         longint unsigned half;
         longint unsigned half_sq;
         longint unsigned term;
         longint unsigned div;
         longint unsigned sine;
         longint unsigned scaled;
         longint          acc;
         int              k;
         half    = r;
         half    = (half * 64'd31415 * (64'd1 << 28) + 64'd1800000) / 64'd3600000;
         half_sq = (half * half) >> 28;
         term    = half;
         acc     = longint'(half);
         for (k = 1; k <= 6; k++) begin
            div  = (2 * k) * (2 * k + 1);
            term = ((term * half_sq) >> 28) / div;
            if (k % 2 == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         sine   = longint'(acc);
         scaled = d;
         scaled = (64'd8 * scaled * sine + (64'd1 << 27)) >> 28;
         if (scaled > 64'd4095) begin
            return sos_pkg::LIN_MAX;
         end
         return sos_pkg::LIN_W'(scaled);
      endfunction

      function void note_request(sos_pkg::action_type act, logic [sos_pkg::ANGLE_W-1:0] ang,
                                 logic [sos_pkg::DIST_W-1:0] dist_cm);
         sweep_result_type             r;
         logic [sos_pkg::ANGLE_W-1:0]  span;
         if (act == sos_pkg::ACTION_END) begin
            r      = have_best ? best : '0;
            r.kind = sos_pkg::KIND_SUMMARY;
            awaited.push_back(r);
            restart_sweep();
            return;
         end
         if (dist_cm < threshold) begin
            if (!in_run) begin
               run_first = ang;
            end
            in_run   = 1'b1;
            run_last = ang;
            run_dist = dist_cm;
            return;
         end
         if (!in_run || run_last == run_first) begin
            return;
         end
         span   = (run_last > run_first) ? run_last - run_first : run_first - run_last;
         in_run = 1'b0;
         if (found >= sos_pkg::MAX_OBJECTS_DEF) begin
            capacity_drops++;
            return;
         end
         found++;
         r.kind     = sos_pkg::KIND_OBJECT;
         r.number   = sos_pkg::NUM_W'(found);
         r.mid      = sos_pkg::MID_W'(run_first) + sos_pkg::MID_W'(run_last);
         r.distance = run_dist;
         r.radial   = span;
         r.chord    = chord_q2(run_dist, span);
         if (!have_best || r.chord < best.chord) begin
            have_best = 1'b1;
            best      = r;
         end
         awaited.push_back(r);
      endfunction

      function void check_response(sweep_result_type got);
         sweep_result_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: unexpected response kind %0d number %0d mid %0d",
                        got.kind, got.number, got.mid);
               $display("          dist %0d width %0d chord %0d",
                        got.distance, got.radial, got.chord);
            end
            return;
         end
         want = awaited.pop_front();
         if (want.kind == sos_pkg::KIND_SUMMARY) begin
            summaries_checked++;
         end else begin
            objects_checked++;
         end
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: expected kind %0d number %0d mid %0d dist %0d width %0d",
                        want.kind, want.number, want.mid, want.distance, want.radial);
               $display("          expected chord %0d", want.chord);
               $display("          actual   kind %0d number %0d mid %0d dist %0d width %0d",
                        got.kind, got.number, got.mid, got.distance, got.radial);
               $display("          actual   chord %0d", got.chord);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   sos_req_if req_bus ();
   sos_rsp_if rsp_bus ();
   sos_csr_if csr_bus ();

   sweep_object_segmenter_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   sweep_scoreboard board = new();

   int requests_sent   = 0;
   int threshold_writes = 0;
   int req_idle_rate   = 0;
   int rsp_stall_rate  = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      sweep_result_type seen;
      int               stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            seen.kind     = sos_pkg::kind_type'(rsp_bus.kind);
            seen.number   = rsp_bus.object_number;
            seen.mid      = rsp_bus.mid_angle_half_deg;
            seen.distance = rsp_bus.object_distance;
            seen.radial   = rsp_bus.radial_width_deg;
            seen.chord    = rsp_bus.linear_width_q2;
            board.check_response(seen);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_stall_rate != 0 && $urandom_range(0, rsp_stall_rate - 1) == 0) begin
            stall_left = $urandom_range(0, 16);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_request(input sos_pkg::action_type act,
                               input logic [sos_pkg::ANGLE_W-1:0] ang,
                               input logic [sos_pkg::DIST_W-1:0] dist_cm);
      int gap;
      if (req_idle_rate != 0 && $urandom_range(0, req_idle_rate - 1) == 0) begin
         gap = $urandom_range(1, 17);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.action      <= act;
      req_bus.angle_deg   <= ang;
      req_bus.distance_cm <= dist_cm;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      board.note_request(act, ang, dist_cm);
      requests_sent++;
   endtask

   task automatic sample(input int ang, input int dist_cm);
      send_request(sos_pkg::ACTION_SAMPLE, sos_pkg::ANGLE_W'(ang), sos_pkg::DIST_W'(dist_cm));
   endtask

   task automatic end_sweep();
      send_request(sos_pkg::ACTION_END, sos_pkg::ANGLE_W'($urandom_range(0, 180)),
                   sos_pkg::DIST_W'($urandom_range(0, 511)));
   endtask

   task automatic drain_pipeline();
      req_bus.valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [sos_pkg::DIST_W-1:0] value);
      drain_pipeline();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      board.threshold = value;
      threshold_writes++;
   endtask

   function automatic int near_dist();
      int t;
      t = board.threshold;
      if (t == 0) begin
         return 0;
      end
      return $urandom_range(0, t - 1);
   endfunction

   function automatic int far_dist();
      int t;
      t = board.threshold;
      return $urandom_range(t, 511);
   endfunction

   task automatic sweep_walk();
      int ang;
      int stop;
      int len;
      int i;
      int fix_len;
      int fix_dist;
      bit fixed;
      ang      = $urandom_range(0, 40);
      stop     = $urandom_range(ang + 20, 180);
      fixed    = ($urandom_range(0, 3) == 0);
      fix_dist = near_dist();
      fix_len  = $urandom_range(2, 6);
      while (ang <= stop) begin
         len = fixed ? fix_len : $urandom_range(1, 8);
         for (i = 0; i < len && ang <= stop; i++) begin
            sample(ang, fixed ? fix_dist : near_dist());
            ang++;
         end
         len = $urandom_range(1, 5);
         for (i = 0; i < len && ang <= stop; i++) begin
            sample(ang, far_dist());
            ang++;
         end
         if ($urandom_range(0, 19) == 0) begin
            sample($urandom_range(0, 180), near_dist());
         end
      end
   endtask

   task automatic sweep_dense();
      int ang;
      int fix_dist;
      bit fixed;
      fixed    = ($urandom_range(0, 1) == 0);
      fix_dist = near_dist();
      for (ang = $urandom_range(0, 20); ang <= 180; ang++) begin
         if (ang % 3 == 2) begin
            sample(ang, far_dist());
         end else begin
            sample(ang, fixed ? fix_dist : near_dist());
         end
      end
   endtask

   task automatic sweep_noise(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 11) == 0) begin
            end_sweep();
         end else begin
            sample($urandom_range(0, 180), $urandom_range(0, 511));
         end
      end
   endtask

   function automatic int pick_rate();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 20;
         2: return 6;
         default: return 3;
      endcase
   endfunction

   function automatic int pick_threshold(input int phase);
      case (phase)
         0: return 0;
         2: return 511;
         4: return 1;
         default: begin
            if ($urandom_range(0, 3) == 0) begin
               return $urandom_range(0, 511);
            end
            return $urandom_range(40, 300);
         end
      endcase
   endfunction

   initial begin
      int phase;
      int failures;
      int style;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.action      = sos_pkg::ACTION_SAMPLE;
      req_bus.angle_deg   = '0;
      req_bus.distance_cm = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.data        = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      end_sweep();
      sample(10, 50);
      sample(11, 200);
      sample(12, 99);
      sample(13, 100);
      sample(180, 0);
      sample(0, 511);
      sample(0, 1);
      sample(5, 300);
      sample(20, 99);
      sample(22, 99);
      sample(23, 150);
      sample(30, 0);
      sample(31, 0);
      sample(32, 511);
      sample(40, 0);
      sample(41, 0);
      sample(42, 200);
      sample(50, 10);
      end_sweep();
      sample(170, 3);
      sample(180, 3);
      sample(179, 400);
      end_sweep();

      phase = 0;
      while (requests_sent < 1040) begin
         if (requests_sent > 880) begin
            req_idle_rate  = 0;
            rsp_stall_rate = 0;
         end else begin
            req_idle_rate  = pick_rate();
            rsp_stall_rate = pick_rate();
         end
         if (phase % 2 == 0) begin
            write_threshold(sos_pkg::DIST_W'(pick_threshold(phase)));
         end else if (phase % 5 == 1) begin
            drain_pipeline();
         end
         if (board.threshold == 0) begin
            sweep_noise(20);
         end else begin
            style = $urandom_range(0, 9);
            if (style < 6) begin
               sweep_walk();
            end else if (style < 8) begin
               sweep_dense();
            end else begin
               sweep_noise($urandom_range(15, 40));
            end
         end
         end_sweep();
         phase++;
      end

      rsp_stall_rate = 0;
      drain_pipeline();
      repeat (10) @(posedge clock);

      failures = board.mismatches + board.awaited.size();
      $display("covered %0d requests in %0d sweep phases under %0d threshold settings",
               requests_sent, phase, threshold_writes);
      $display("checked %0d objects and %0d summaries, %0d objects past capacity, %0d mismatches",
               board.objects_checked, board.summaries_checked, board.capacity_drops,
               board.mismatches);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
